// ===== sv/ccthr_pkg.sv =====
// Package of shared types and constants for the cruise control throttle machine.
`default_nettype none
package ccthr_pkg;

	localparam int unsigned ThrW   = 8;
	localparam int unsigned SpeedW = 10;
	localparam int unsigned CfgIdxW  = 2;
	localparam int unsigned CfgDataW = 10;

	typedef enum logic [1:0] {
		MODE_IDLE   = 2'd0,
		MODE_INIT   = 2'd1,
		MODE_ACTIVE = 2'd2,
		MODE_EXIT   = 2'd3
	} mode_t;

	typedef enum logic [CfgIdxW-1:0] {
		REG_PEDAL_STEP       = 2'd0,
		REG_CRUISE_STEP      = 2'd1,
		REG_THROTTLE_MAX     = 2'd2,
		REG_MIN_CRUISE_SPEED = 2'd3
	} reg_idx_t;

	localparam logic [ThrW-1:0]   PedalStepRst      = 8'd2;
	localparam logic [ThrW-1:0]   CruiseStepRst     = 8'd8;
	localparam logic [ThrW-1:0]   ThrottleMaxRst    = 8'd80;
	localparam logic [SpeedW-1:0] MinCruiseSpeedRst = 10'd25;

	typedef struct packed {
		logic [ThrW-1:0]   pedal_step;
		logic [ThrW-1:0]   cruise_step;
		logic [ThrW-1:0]   throttle_max;
		logic [SpeedW-1:0] min_cruise_speed;
	} cfg_t;

	typedef struct packed {
		logic              cruise_button;
		logic              gas_pressed;
		logic              brake_pressed;
		logic [SpeedW-1:0] speed;
	} item_t;

	typedef struct packed {
		logic [ThrW-1:0]   throttle_out;
		mode_t             mode_out;
		logic              cruise_lamp;
		logic [SpeedW-1:0] target_out;
	} res_t;

	// Add with saturation; a base already above the limit comes back as the limit.
	function automatic logic [ThrW-1:0] sat_add(input logic [ThrW-1:0] base,
			input logic [ThrW-1:0] step, input logic [ThrW-1:0] limit);
		logic [ThrW:0] sum;
		sum = {1'b0, base} + {1'b0, step};
		sat_add = (sum > {1'b0, limit}) ? limit : sum[ThrW-1:0];
	endfunction

endpackage
`default_nettype wire

// ===== sv/ccthr_ifs.sv =====
// Handshake interfaces for the input, result and configuration channels.
`default_nettype none
interface ccthr_item_if;
	logic                           valid;
	logic                           ready;
	logic                           cruise_button;
	logic                           gas_pressed;
	logic                           brake_pressed;
	logic [ccthr_pkg::SpeedW-1:0]   speed;
	modport source (output valid, cruise_button, gas_pressed, brake_pressed, speed,
		input ready);
	modport sink (input valid, cruise_button, gas_pressed, brake_pressed, speed,
		output ready);
endinterface

interface ccthr_result_if;
	logic                           valid;
	logic                           ready;
	logic [ccthr_pkg::ThrW-1:0]     throttle_out;
	logic [1:0]                     mode_out;
	logic                           cruise_lamp;
	logic [ccthr_pkg::SpeedW-1:0]   target_out;
	modport source (output valid, throttle_out, mode_out, cruise_lamp, target_out,
		input ready);
	modport sink (input valid, throttle_out, mode_out, cruise_lamp, target_out,
		output ready);
endinterface

interface ccthr_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [ccthr_pkg::CfgIdxW-1:0]  index;
	logic [ccthr_pkg::CfgDataW-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== sv/ccthr_regs.sv =====
// Configuration register file: step sizes, throttle limit and minimum cruise speed.
`default_nettype none
module ccthr_regs (
	input  wire logic      clk,
	input  wire logic      arst_n,
	ccthr_cfg_if.sink      cfg,
	output ccthr_pkg::cfg_t regs
);
	import ccthr_pkg::*;

	cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.pedal_step       <= PedalStepRst;
			regs_q.cruise_step      <= CruiseStepRst;
			regs_q.throttle_max     <= ThrottleMaxRst;
			regs_q.min_cruise_speed <= MinCruiseSpeedRst;
		end else if (cfg.valid) begin
			case (reg_idx_t'(cfg.index))
				REG_PEDAL_STEP:       regs_q.pedal_step       <= cfg.data[ThrW-1:0];
				REG_CRUISE_STEP:      regs_q.cruise_step      <= cfg.data[ThrW-1:0];
				REG_THROTTLE_MAX:     regs_q.throttle_max     <= cfg.data[ThrW-1:0];
				REG_MIN_CRUISE_SPEED: regs_q.min_cruise_speed <= cfg.data[SpeedW-1:0];
				default: ;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== sv/ccthr_fsm.sv =====
// Cruise mode machine with throttle, lamp and target registers, one tick per step.
`default_nettype none
module ccthr_fsm (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             step_en,
	input  wire ccthr_pkg::item_t item,
	input  wire ccthr_pkg::cfg_t  regs,
	output ccthr_pkg::res_t       res
);
	import ccthr_pkg::*;

	mode_t             mode_q, mode_n;
	logic [SpeedW-1:0] target_q, target_n;
	logic [ThrW-1:0]   throttle_q, throttle_n;
	logic              lamp_q, lamp_n;
	logic [ThrW-1:0]   thr_m;

	always_comb begin
		mode_n = mode_q;
		case (mode_q)
			MODE_IDLE: begin
				if (item.cruise_button) mode_n = MODE_INIT;
			end
			MODE_INIT: begin
				if (!item.cruise_button) mode_n = MODE_ACTIVE;
			end
			MODE_ACTIVE: begin
				if (item.cruise_button) begin
					mode_n = MODE_EXIT;
				end else if (item.gas_pressed || item.brake_pressed ||
						item.speed < regs.min_cruise_speed) begin
					mode_n = MODE_IDLE;
				end
			end
			MODE_EXIT: begin
				if (!item.cruise_button) mode_n = MODE_IDLE;
			end
			default: mode_n = MODE_IDLE;
		endcase
	end

	always_comb begin
		lamp_n   = lamp_q;
		target_n = target_q;
		thr_m    = throttle_q;
		case (mode_q)
			MODE_IDLE: lamp_n = 1'b0;
			MODE_INIT: begin
				if (!item.cruise_button) target_n = item.speed;
			end
			MODE_ACTIVE: begin
				lamp_n = 1'b1;
				if (target_q < item.speed) begin
					thr_m = '0;
				end else if (target_q > item.speed) begin
					thr_m = sat_add(throttle_q, regs.cruise_step, regs.throttle_max);
				end
			end
			default: ;
		endcase
		// The pedal step is applied after the machine, on top of any cruise step.
		if (item.gas_pressed) begin
			throttle_n = sat_add(thr_m, regs.pedal_step, regs.throttle_max);
		end else if (mode_n == MODE_IDLE) begin
			throttle_n = '0;
		end else begin
			throttle_n = thr_m;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_IDLE;
			target_q   <= '0;
			throttle_q <= '0;
			lamp_q     <= 1'b0;
		end else if (step_en) begin
			mode_q     <= mode_n;
			target_q   <= target_n;
			throttle_q <= throttle_n;
			lamp_q     <= lamp_n;
		end
	end

	assign res.throttle_out = throttle_n;
	assign res.mode_out     = mode_n;
	assign res.cruise_lamp  = lamp_n;
	assign res.target_out   = target_n;

	a_idle_lamp: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && mode_q == MODE_IDLE |=> !lamp_q)
		else $error("lamp not cleared after an idle tick");
	a_active_lamp: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && mode_q == MODE_ACTIVE |=> lamp_q)
		else $error("lamp not set after an active tick");
	a_idle_thr: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && !item.gas_pressed && mode_n == MODE_IDLE |=> throttle_q == '0)
		else $error("throttle not zero in idle without gas");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!step_en |=> $stable(mode_q) && $stable(throttle_q) && $stable(target_q))
		else $error("state changed without a tick");

endmodule
`default_nettype wire

// ===== sv/cruise_control_throttle_fsm.sv =====
// Top level of the cruise control throttle machine: input and result registers around the FSM.
// One request is taken per clock unless a stalled result holds the input register back; the
// mode/throttle update works on the input register and lands in the result register as the
// request leaves the input register. A stalled result lets one more request into the input
// register before the input is held off. Configuration writes are taken at once, every cycle;
// an item's throttle step uses the registers as they stand when it leaves the input register.
`default_nettype none
module cruise_control_throttle_fsm (
	input  wire logic     clk,
	input  wire logic     arst_n,
	ccthr_item_if.sink    item,
	ccthr_result_if.source result,
	ccthr_cfg_if.sink     cfg
);
	import ccthr_pkg::*;

	cfg_t  regs;
	item_t item_s1;
	logic  valid_s1;
	res_t  res_c, res_s2;
	logic  valid_s2;
	logic  advance;

	ccthr_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	ccthr_fsm u_fsm (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (advance),
		.item    (item_s1),
		.regs    (regs),
		.res     (res_c)
	);

	assign advance    = valid_s1 && (!valid_s2 || result.ready);
	assign item.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (item.ready) valid_s1 <= item.valid;
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (result.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			item_s1.cruise_button <= item.cruise_button;
			item_s1.gas_pressed   <= item.gas_pressed;
			item_s1.brake_pressed <= item.brake_pressed;
			item_s1.speed         <= item.speed;
		end
		if (advance) res_s2 <= res_c;
	end

	assign result.valid        = valid_s2;
	assign result.throttle_out = res_s2.throttle_out;
	assign result.mode_out     = res_s2.mode_out;
	assign result.cruise_lamp  = res_s2.cruise_lamp;
	assign result.target_out   = res_s2.target_out;

	a_full_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |-> !item.ready)
		else $error("request taken while the input register is blocked");
	a_adv_out: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> valid_s2)
		else $error("result lost after a tick");
	a_adv_src: assert property (@(posedge clk) disable iff (!arst_n)
		advance |-> valid_s1)
		else $error("tick without a pending request");

endmodule
`default_nettype wire

// ===== tb/cruise_throttle_checker.sv =====
// Checker for the cruise control throttle machine: predicts every tick and compares the results.
module cruise_throttle_checker (
	input  logic           clk,
	input  logic           arst_n,
	ccthr_item_if          item,
	ccthr_result_if        result,
	ccthr_cfg_if           cfg,
	output int             errors,
	output int             pending,
	output int             ticks_checked,
	output int             cruise_ticks
);
	timeunit 1ns;
	timeprecision 1ps;
	import ccthr_pkg::*;

	// Register copy and machine state as the block should hold them.
	cfg_t              regs;
	mode_t             mode_q;
	logic [SpeedW-1:0] target_q;
	logic [ThrW-1:0]   throttle_q;
	logic              lamp_q;

	res_t expected_ticks[$];
	int   err_cnt = 0;
	int   tick_cnt = 0;
	int   active_cnt = 0;

	function automatic logic [ThrW-1:0] step_clamped(input logic [ThrW-1:0] cur,
			input logic [ThrW-1:0] step, input logic [ThrW-1:0] lim);
		int unsigned total;
		total = cur + step;
		return (total > lim) ? lim : total[ThrW-1:0];
	endfunction

	// Advances the predicted machine by one tick and returns what the block should report.
	function automatic res_t next_tick(input item_t it);
		res_t r;
		case (mode_q)
			MODE_IDLE: begin
				lamp_q = 1'b0;
				if (it.cruise_button)
					mode_q = MODE_INIT;
			end
			MODE_INIT: begin
				if (!it.cruise_button) begin
					mode_q = MODE_ACTIVE;
					target_q = it.speed;
				end
			end
			MODE_ACTIVE: begin
				lamp_q = 1'b1;
				if (it.gas_pressed || it.brake_pressed || it.speed < regs.min_cruise_speed)
					mode_q = MODE_IDLE;
				// The button wins over the pedals and the speed floor.
				if (it.cruise_button)
					mode_q = MODE_EXIT;
				if (target_q < it.speed)
					throttle_q = '0;
				else if (target_q > it.speed)
					throttle_q = step_clamped(throttle_q, regs.cruise_step, regs.throttle_max);
			end
			default: begin
				if (!it.cruise_button)
					mode_q = MODE_IDLE;
			end
		endcase
		if (it.gas_pressed)
			throttle_q = step_clamped(throttle_q, regs.pedal_step, regs.throttle_max);
		else if (mode_q == MODE_IDLE)
			throttle_q = '0;
		r.throttle_out = throttle_q;
		r.mode_out     = mode_q;
		r.cruise_lamp  = lamp_q;
		r.target_out   = target_q;
		return r;
	endfunction

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			err_cnt++;
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		res_t  want;
		item_t it;
		if (!arst_n) begin
			regs.pedal_step       = PedalStepRst;
			regs.cruise_step      = CruiseStepRst;
			regs.throttle_max     = ThrottleMaxRst;
			regs.min_cruise_speed = MinCruiseSpeedRst;
			mode_q     = MODE_IDLE;
			target_q   = '0;
			throttle_q = '0;
			lamp_q     = 1'b0;
			expected_ticks.delete();
		end else begin
			if (result.valid && result.ready) begin
				tick_cnt++;
				if (expected_ticks.size() == 0) begin
					err_cnt++;
					$display("%0t: result with nothing outstanding, expected none, got throttle %0d mode %0d lamp %0d target %0d",
						$time, result.throttle_out, result.mode_out, result.cruise_lamp,
						result.target_out);
				end else begin
					want = expected_ticks.pop_front();
					check_field("throttle_out", want.throttle_out, result.throttle_out);
					check_field("mode_out", want.mode_out, result.mode_out);
					check_field("cruise_lamp", want.cruise_lamp, result.cruise_lamp);
					check_field("target_out", want.target_out, result.target_out);
				end
			end
			if (cfg.valid && cfg.ready) begin
				case (reg_idx_t'(cfg.index))
					REG_PEDAL_STEP:       regs.pedal_step = cfg.data[ThrW-1:0];
					REG_CRUISE_STEP:      regs.cruise_step = cfg.data[ThrW-1:0];
					REG_THROTTLE_MAX:     regs.throttle_max = cfg.data[ThrW-1:0];
					REG_MIN_CRUISE_SPEED: regs.min_cruise_speed = cfg.data;
					default: ;
				endcase
			end
			if (item.valid && item.ready) begin
				it.cruise_button = item.cruise_button;
				it.gas_pressed   = item.gas_pressed;
				it.brake_pressed = item.brake_pressed;
				it.speed         = item.speed;
				want = next_tick(it);
				if (want.mode_out == MODE_ACTIVE)
					active_cnt++;
				expected_ticks.push_back(want);
			end
		end
		errors        <= err_cnt;
		pending       <= expected_ticks.size();
		ticks_checked <= tick_cnt;
		cruise_ticks  <= active_cnt;
	end

endmodule

// ===== tb/cruise_control_throttle_fsm_tb.sv =====
// Top of the testbench: clock, reset, stimulus, receiver stalls and the verdict.
module cruise_control_throttle_fsm_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import ccthr_pkg::*;

	localparam int CycleLimit = 200000;

	logic clk = 1'b0;
	logic arst_n;

	always #10 clk = ~clk;

	ccthr_item_if   item_ch();
	ccthr_result_if result_ch();
	ccthr_cfg_if    cfg_ch();

	int errors;
	int pending;
	int ticks_checked;
	int cruise_ticks;

	bit                src_gaps = 1'b1;
	bit                snk_gaps = 1'b1;
	int                hold_left = 0;
	int                items_sent = 0;
	int                reg_writes = 0;
	int                cycles = 0;
	logic [SpeedW-1:0] cur_min_speed = MinCruiseSpeedRst;

	cruise_control_throttle_fsm DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	cruise_throttle_checker checker_i (
		.clk           (clk),
		.arst_n        (arst_n),
		.item          (item_ch),
		.result        (result_ch),
		.cfg           (cfg_ch),
		.errors        (errors),
		.pending       (pending),
		.ticks_checked (ticks_checked),
		.cruise_ticks  (cruise_ticks)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CycleLimit) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Receiver: random back-pressure, plus a long hold-off counted down here.
	initial begin
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				result_ch.ready <= 1'b0;
				hold_left--;
			end else begin
				result_ch.ready <= !(snk_gaps && $urandom_range(99) < 11);
			end
		end
	end

	task automatic send_tick(input logic button, input logic gas, input logic brake,
			input logic [SpeedW-1:0] spd);
		// An occasional single idle cycle before the request.
		if (src_gaps && $urandom_range(99) < 12) begin
			item_ch.valid <= 1'b0;
			@(posedge clk);
		end
		item_ch.valid         <= 1'b1;
		item_ch.cruise_button <= button;
		item_ch.gas_pressed   <= gas;
		item_ch.brake_pressed <= brake;
		item_ch.speed         <= spd;
		@(posedge clk);
		while (!item_ch.ready)
			@(posedge clk);
		items_sent++;
	endtask

	// Stops offering requests and waits until every result has been taken.
	task automatic drain();
		item_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	// Writes all four registers; the unused upper bits of the 8-bit ones get random values.
	task automatic configure(input logic [ThrW-1:0] pedal_step, input logic [ThrW-1:0] cruise_step,
			input logic [ThrW-1:0] thr_max, input logic [SpeedW-1:0] min_speed);
		reg_idx_t          order[4];
		logic [SpeedW-1:0] vals[4];
		order = '{REG_PEDAL_STEP, REG_CRUISE_STEP, REG_THROTTLE_MAX, REG_MIN_CRUISE_SPEED};
		vals[0] = {2'($urandom_range(3)), pedal_step};
		vals[1] = {2'($urandom_range(3)), cruise_step};
		vals[2] = {2'($urandom_range(3)), thr_max};
		vals[3] = min_speed;
		cfg_ch.valid <= 1'b1;
		for (int i = 0; i < 4; i++) begin
			cfg_ch.index <= order[i];
			cfg_ch.data  <= vals[i];
			@(posedge clk);
			while (!cfg_ch.ready)
				@(posedge clk);
			reg_writes++;
		end
		cfg_ch.valid <= 1'b0;
		cur_min_speed = min_speed;
	endtask

	// One drive with cruise: press, release at the target, hover around it, and maybe leave with the button.
	task automatic cruise_session();
		int   tgt;
		int   spd;
		logic btn;
		repeat ($urandom_range(2))
			send_tick(1'b0, $urandom_range(99) < 20, $urandom_range(99) < 20,
				10'($urandom_range(1023)));
		repeat ($urandom_range(3, 1))
			send_tick(1'b1, 1'b0, 1'b0, 10'($urandom_range(1023)));
		tgt = $urandom_range(1023, cur_min_speed);
		send_tick(1'b0, 1'b0, 1'b0, 10'(tgt));
		repeat ($urandom_range(24, 3)) begin
			// Mostly below the target so that the throttle climbs to its limit.
			spd = tgt + int'($urandom_range(30)) - 22;
			if ($urandom_range(99) < 3)
				spd = $urandom_range(1023);
			if (spd < 0)
				spd = 0;
			if (spd > 1023)
				spd = 1023;
			btn = $urandom_range(99) < 6;
			send_tick(btn, $urandom_range(99) < 4, $urandom_range(99) < 4, 10'(spd));
			if (btn) begin
				repeat ($urandom_range(2))
					send_tick(1'b1, $urandom_range(99) < 10, 1'b0, 10'(spd));
				send_tick(1'b0, 1'b0, 1'b0, 10'(spd));
				break;
			end
		end
	endtask

	task automatic run_phase(input int count);
		int stop_at;
		stop_at = items_sent + count;
		while (items_sent < stop_at) begin
			if ($urandom_range(99) < 15)
				send_tick(1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)),
					10'($urandom_range(1023)));
			else
				cruise_session();
		end
	endtask

	initial begin
		arst_n                <= 1'b0;
		item_ch.valid         <= 1'b0;
		item_ch.cruise_button <= 1'b0;
		item_ch.gas_pressed   <= 1'b0;
		item_ch.brake_pressed <= 1'b0;
		item_ch.speed         <= '0;
		cfg_ch.valid          <= 1'b0;
		cfg_ch.index          <= REG_PEDAL_STEP;
		cfg_ch.data           <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part on the reset settings: gas in idle, capture at full speed,
		// climb to the limit, then the special cases around the limit and the target.
		send_tick(1'b0, 1'b1, 1'b0, 10'd0);
		send_tick(1'b1, 1'b0, 1'b1, 10'd1023);
		send_tick(1'b1, 1'b0, 1'b0, 10'd0);
		send_tick(1'b0, 1'b0, 1'b0, 10'd1023);
		send_tick(1'b0, 1'b0, 1'b0, 10'd1023);
		repeat (10)
			send_tick(1'b0, 1'b0, 1'b0, 10'd500);
		drain();
		// Lowering the limit below the present throttle, still in active cruise.
		configure(8'd2, 8'd8, 8'd10, 10'd25);
		send_tick(1'b0, 1'b0, 1'b0, 10'd1023);
		send_tick(1'b0, 1'b0, 1'b0, 10'd1000);
		send_tick(1'b1, 1'b0, 1'b0, 10'd1000);
		send_tick(1'b1, 1'b1, 1'b0, 10'd1000);
		send_tick(1'b0, 1'b0, 1'b0, 10'd1000);
		// Zero target: any speed is above it; then the speed floor and the gas pedal.
		send_tick(1'b1, 1'b0, 1'b0, 10'd5);
		send_tick(1'b0, 1'b0, 1'b0, 10'd0);
		send_tick(1'b0, 1'b0, 1'b0, 10'd30);
		send_tick(1'b0, 1'b0, 1'b0, 10'd3);
		send_tick(1'b1, 1'b0, 1'b0, 10'd100);
		send_tick(1'b0, 1'b0, 1'b0, 10'd100);
		send_tick(1'b0, 1'b1, 1'b0, 10'd90);
		drain();

		configure(PedalStepRst, CruiseStepRst, ThrottleMaxRst, MinCruiseSpeedRst);
		run_phase(110);
		drain();
		configure(8'd0, 8'd0, 8'd0, 10'd0);
		run_phase(100);
		drain();
		configure(8'd255, 8'd255, 8'd255, 10'd1023);
		run_phase(90);
		drain();

		src_gaps = 1'b0;
		snk_gaps = 1'b0;
		configure(8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)),
			10'($urandom_range(200)));
		run_phase(110);
		drain();
		snk_gaps = 1'b1;

		// Long receiver hold-off while requests keep coming, then a full pause mid-phase.
		configure(8'($urandom_range(16)), 8'($urandom_range(32)), 8'($urandom_range(255, 40)),
			10'($urandom_range(100)));
		hold_left = 60;
		run_phase(100);
		drain();
		src_gaps = 1'b1;
		run_phase(50);
		drain();

		configure(8'd1, 8'd1, 8'd255, 10'd0);
		run_phase(90);
		drain();
		configure(8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)),
			10'($urandom_range(1023)));
		run_phase(90);
		drain();

		repeat (10) @(posedge clk);
		$display("Checked %0d ticks, %0d of them in active cruise, across %0d register writes.",
			ticks_checked, cruise_ticks, reg_writes);
		$display("Settings ranged from all-zero to full-scale, with a long result stall and a full drain.");
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// ===== sim.f =====
sv/ccthr_pkg.sv
sv/ccthr_ifs.sv
sv/ccthr_regs.sv
sv/ccthr_fsm.sv
sv/cruise_control_throttle_fsm.sv
tb/cruise_throttle_checker.sv
tb/cruise_control_throttle_fsm_tb.sv
